// ===== hdl/ptb_pkg.sv =====
// ----------------------------------------------------------------------------
// ptb_pkg
// Shared constants, node record and sequencer states of the eertree builder.
// ----------------------------------------------------------------------------
package ptb_pkg;

  localparam int MAX_LEN     = 4096;
  localparam int ALPHABET    = 26;
  localparam int NODE_CAP    = MAX_LEN + 2;
  localparam int TEXT_DEPTH  = MAX_LEN + 1;
  localparam int CHILD_DEPTH = NODE_CAP * ALPHABET;

  localparam int LETTER_W = 5;
  localparam int POS_W    = $clog2(MAX_LEN + 1);
  localparam int NODE_W   = $clog2(NODE_CAP);
  localparam int CHILD_AW = $clog2(CHILD_DEPTH);

  localparam logic [NODE_W-1:0] IMAG_ROOT  = NODE_W'(0);
  localparam logic [NODE_W-1:0] EMPTY_ROOT = NODE_W'(1);
  localparam logic [NODE_W-1:0] FIRST_NODE = NODE_W'(2);

  typedef struct packed {
    logic [POS_W-1:0]    len;
    logic [NODE_W-1:0]   link;
    logic [NODE_W-1:0]   parent;
    logic [LETTER_W-1:0] letter;
  } node_word_t;

  localparam int NODE_WORD_W = $bits(node_word_t);

  typedef enum logic [2:0] {
    S_IDLE,
    S_WSTART,
    S_WNODE,
    S_WTXT,
    S_CADDR,
    S_CWAIT,
    S_CCHK,
    S_OUT
  } ptb_state_t;

endpackage

// ===== hdl/ptb_in_if.sv =====
// ----------------------------------------------------------------------------
// ptb_in_if
// Letter channel: valid/ready handshake with letter and first flag.
// ----------------------------------------------------------------------------
interface ptb_in_if;
  logic                          valid;
  logic                          ready;
  logic [ptb_pkg::LETTER_W-1:0]  letter;
  logic                          first;

  modport source (output valid, output letter, output first, input ready);
  modport sink (input valid, input letter, input first, output ready);
endinterface

// ===== hdl/ptb_out_if.sv =====
// ----------------------------------------------------------------------------
// ptb_out_if
// Result channel: valid/ready handshake with the suffix palindrome report.
// ----------------------------------------------------------------------------
interface ptb_out_if;
  logic                        valid;
  logic                        ready;
  logic [ptb_pkg::NODE_W-1:0]  suffix_node;
  logic [ptb_pkg::POS_W-1:0]   palindrome_length;
  logic [ptb_pkg::NODE_W-1:0]  suffix_link_node;
  logic                        is_new;
  logic [ptb_pkg::NODE_W-1:0]  node_count;
  logic                        overflow;

  modport source (
    output valid, output suffix_node, output palindrome_length,
    output suffix_link_node, output is_new, output node_count, output overflow,
    input ready
  );
  modport sink (
    input valid, input suffix_node, input palindrome_length,
    input suffix_link_node, input is_new, input node_count, input overflow,
    output ready
  );
endinterface

// ===== hdl/ptb_ram.sv =====
// ----------------------------------------------------------------------------
// ptb_ram
// Generic single write port, single read port RAM with registered read.
// ----------------------------------------------------------------------------
module ptb_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                                    clk,
  input  logic                                    we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                        wdata,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                        rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== hdl/palindromic_tree_builder_unit.sv =====
// Timing: an ignored letter presents its result in the cycle after acceptance;
//   other letters first walk suffix links (the main walk and, for a new node, the
//   link walk). A new letter is taken only in the idle state, once the previous
//   result has been taken. Reset: synchronous; both roots preset, no memory
//   clearing pass, child entries checked against each parent record.
// ----------------------------------------------------------------------------
// palindromic_tree_builder_unit
// Online eertree builder: suffix-link walks run on a small sequencer that
// shares one node memory read port, one text read port and one child table.
// ----------------------------------------------------------------------------
module palindromic_tree_builder_unit (
  input  logic           clk,
  input  logic           rst,
  ptb_in_if.sink         in_item,
  ptb_out_if.source      out_item
);

  localparam int NODE_W   = ptb_pkg::NODE_W;
  localparam int POS_W    = ptb_pkg::POS_W;
  localparam int LETTER_W = ptb_pkg::LETTER_W;
  localparam int CHILD_AW = ptb_pkg::CHILD_AW;

  ptb_pkg::ptb_state_t state, state_next;

  logic [LETTER_W-1:0] ch, ch_next;
  logic [POS_W-1:0]    position, position_next;
  logic [NODE_W-1:0]   last_node, last_node_next;
  logic [POS_W-1:0]    last_len, last_len_next;
  logic [NODE_W-1:0]   last_link, last_link_next;
  logic [NODE_W-1:0]   nodes_used, nodes_used_next;
  logic [NODE_W-1:0]   cur, cur_next;
  logic [POS_W-1:0]    cur_len, cur_len_next;
  logic [NODE_W-1:0]   cur_link, cur_link_next;
  logic [NODE_W-1:0]   x_node, x_node_next;
  logic [POS_W-1:0]    x_len2, x_len2_next;
  logic [NODE_W-1:0]   x_link, x_link_next;
  logic [NODE_W-1:0]   cnode, cnode_next;
  logic [NODE_W-1:0]   c_node, c_node_next;
  logic [NODE_W-1:0]   made_node, made_node_next;
  logic [CHILD_AW-1:0] slot, slot_next;
  logic                phase, phase_next;
  logic                created, created_next;
  logic                over, over_next;

  // memory ports
  logic                text_we;
  logic [POS_W-1:0]    text_waddr, text_raddr;
  logic [LETTER_W-1:0] text_wdata, text_rdata;
  logic                node_we;
  logic [NODE_W-1:0]   node_waddr, node_raddr;
  ptb_pkg::node_word_t node_wdata, node_rdata;
  logic [ptb_pkg::NODE_WORD_W-1:0] node_rdata_raw;
  logic                child_we;
  logic [CHILD_AW-1:0] child_waddr, child_raddr;
  logic [NODE_W-1:0]   child_wdata, child_rdata;

  // combinational helpers
  logic [POS_W-1:0]    eff_pos;
  logic [CHILD_AW-1:0] slot_calc;
  logic                found;
  logic                hit, miss;
  logic [NODE_W-1:0]   lk;
  logic                finish;

  assign node_rdata = ptb_pkg::node_word_t'(node_rdata_raw);
  assign slot_calc  = CHILD_AW'(cnode) * CHILD_AW'(ptb_pkg::ALPHABET) + CHILD_AW'(ch);

  ptb_ram #(.WIDTH(LETTER_W), .DEPTH(ptb_pkg::TEXT_DEPTH)) u_text (
    .clk(clk), .we(text_we), .waddr(text_waddr), .wdata(text_wdata),
    .raddr(text_raddr), .rdata(text_rdata)
  );

  ptb_ram #(.WIDTH(ptb_pkg::NODE_WORD_W), .DEPTH(ptb_pkg::NODE_CAP)) u_node (
    .clk(clk), .we(node_we), .waddr(node_waddr), .wdata(node_wdata),
    .raddr(node_raddr), .rdata(node_rdata_raw)
  );

  ptb_ram #(.WIDTH(NODE_W), .DEPTH(ptb_pkg::CHILD_DEPTH)) u_child (
    .clk(clk), .we(child_we), .waddr(child_waddr), .wdata(child_wdata),
    .raddr(child_raddr), .rdata(child_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ptb_pkg::S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next      = state;
    ch_next         = ch;
    position_next   = position;
    last_node_next  = last_node;
    last_len_next   = last_len;
    last_link_next  = last_link;
    nodes_used_next = nodes_used;
    cur_next        = cur;
    cur_len_next    = cur_len;
    cur_link_next   = cur_link;
    x_node_next     = x_node;
    x_len2_next     = x_len2;
    x_link_next     = x_link;
    cnode_next      = cnode;
    c_node_next     = c_node;
    made_node_next  = made_node;
    slot_next       = slot;
    phase_next      = phase;
    created_next    = created;
    over_next       = over;

    text_we     = 1'b0;
    text_waddr  = POS_W'(position + POS_W'(1));
    text_wdata  = ch;
    text_raddr  = '0;
    node_we     = 1'b0;
    node_waddr  = made_node;
    node_wdata  = '0;
    node_raddr  = cur;
    child_we    = 1'b0;
    child_waddr = slot;
    child_wdata = nodes_used;
    child_raddr = slot_calc;

    eff_pos = in_item.first ? '0 : position;
    found   = 1'b0;
    hit     = 1'b0;
    miss    = 1'b0;
    finish  = 1'b0;
    lk      = ptb_pkg::EMPTY_ROOT;

    case (state)
      ptb_pkg::S_IDLE: begin
        if (in_item.valid) begin
          ch_next      = in_item.letter;
          created_next = 1'b0;
          over_next    = 1'b0;
          phase_next   = 1'b0;
          if (in_item.first) begin
            position_next   = '0;
            last_node_next  = ptb_pkg::EMPTY_ROOT;
            last_len_next   = '0;
            last_link_next  = ptb_pkg::IMAG_ROOT;
            nodes_used_next = ptb_pkg::FIRST_NODE;
          end
          if (32'(in_item.letter) >= ptb_pkg::ALPHABET) begin
            state_next = ptb_pkg::S_OUT;
          end else if (32'(eff_pos) >= ptb_pkg::MAX_LEN) begin
            over_next  = 1'b1;
            state_next = ptb_pkg::S_OUT;
          end else begin
            position_next = POS_W'(eff_pos + POS_W'(1));
            text_we       = 1'b1;
            text_waddr    = POS_W'(eff_pos + POS_W'(1));
            text_wdata    = in_item.letter;
            cur_next      = in_item.first ? ptb_pkg::EMPTY_ROOT : last_node;
            state_next    = ptb_pkg::S_WSTART;
          end
        end
      end

      ptb_pkg::S_WSTART: begin
        if (cur == ptb_pkg::IMAG_ROOT) begin
          found = 1'b1;
        end else if (cur == ptb_pkg::EMPTY_ROOT) begin
          cur_len_next  = '0;
          cur_link_next = ptb_pkg::IMAG_ROOT;
          if (position > POS_W'(1)) begin
            text_raddr = POS_W'(position - POS_W'(1));
            state_next = ptb_pkg::S_WTXT;
          end else begin
            cur_next = ptb_pkg::IMAG_ROOT;
          end
        end else begin
          node_raddr = cur;
          state_next = ptb_pkg::S_WNODE;
        end
      end

      ptb_pkg::S_WNODE: begin
        cur_len_next  = node_rdata.len;
        cur_link_next = node_rdata.link;
        if ({1'b0, position} > ({1'b0, node_rdata.len} + (POS_W + 1)'(1))) begin
          text_raddr = POS_W'(position - node_rdata.len - POS_W'(1));
          state_next = ptb_pkg::S_WTXT;
        end else begin
          cur_next   = node_rdata.link;
          state_next = ptb_pkg::S_WSTART;
        end
      end

      ptb_pkg::S_WTXT: begin
        if (text_rdata == ch) begin
          found = 1'b1;
        end else begin
          cur_next   = cur_link;
          state_next = ptb_pkg::S_WSTART;
        end
      end

      ptb_pkg::S_CADDR: begin
        child_raddr = slot_calc;
        slot_next   = slot_calc;
        state_next  = ptb_pkg::S_CWAIT;
      end

      ptb_pkg::S_CWAIT: begin
        c_node_next = child_rdata;
        if (child_rdata >= ptb_pkg::FIRST_NODE && child_rdata < nodes_used) begin
          node_raddr = child_rdata;
          state_next = ptb_pkg::S_CCHK;
        end else begin
          miss = 1'b1;
        end
      end

      ptb_pkg::S_CCHK: begin
        if (node_rdata.parent == cnode && node_rdata.letter == ch) begin
          hit = 1'b1;
        end else begin
          miss = 1'b1;
        end
      end

      ptb_pkg::S_OUT: begin
        if (out_item.ready) begin
          state_next = ptb_pkg::S_IDLE;
        end
      end

      default: begin
        state_next = ptb_pkg::S_IDLE;
      end
    endcase

    if (found) begin
      cnode_next = cur;
      state_next = ptb_pkg::S_CADDR;
      if (!phase) begin
        x_node_next = cur;
        x_len2_next = (cur == ptb_pkg::IMAG_ROOT) ? POS_W'(1) : POS_W'(cur_len + POS_W'(2));
        x_link_next = cur_link;
      end
    end

    if (hit && !phase) begin
      last_node_next = c_node;
      last_len_next  = node_rdata.len;
      last_link_next = node_rdata.link;
      state_next     = ptb_pkg::S_OUT;
    end

    if (miss && !phase) begin
      // new node for this letter
      child_we        = 1'b1;
      child_waddr     = slot;
      child_wdata     = nodes_used;
      made_node_next  = nodes_used;
      nodes_used_next = NODE_W'(nodes_used + NODE_W'(1));
      created_next    = 1'b1;
      if (x_node == ptb_pkg::IMAG_ROOT) begin
        finish = 1'b1;
      end else begin
        cur_next   = x_link;
        phase_next = 1'b1;
        state_next = ptb_pkg::S_WSTART;
      end
    end

    if (phase && (hit || miss)) begin
      finish = 1'b1;
      lk     = hit ? c_node : ptb_pkg::EMPTY_ROOT;
    end

    if (finish) begin
      node_we           = 1'b1;
      node_waddr        = phase ? made_node : nodes_used;
      node_wdata.len    = x_len2;
      node_wdata.link   = lk;
      node_wdata.parent = x_node;
      node_wdata.letter = ch;
      last_node_next    = phase ? made_node : nodes_used;
      last_len_next     = x_len2;
      last_link_next    = lk;
      state_next        = ptb_pkg::S_OUT;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      position   <= '0;
      last_node  <= ptb_pkg::EMPTY_ROOT;
      last_len   <= '0;
      last_link  <= ptb_pkg::IMAG_ROOT;
      nodes_used <= ptb_pkg::FIRST_NODE;
      phase      <= 1'b0;
      created    <= 1'b0;
      over       <= 1'b0;
    end else begin
      position   <= position_next;
      last_node  <= last_node_next;
      last_len   <= last_len_next;
      last_link  <= last_link_next;
      nodes_used <= nodes_used_next;
      phase      <= phase_next;
      created    <= created_next;
      over       <= over_next;
    end
    ch        <= ch_next;
    cur       <= cur_next;
    cur_len   <= cur_len_next;
    cur_link  <= cur_link_next;
    x_node    <= x_node_next;
    x_len2    <= x_len2_next;
    x_link    <= x_link_next;
    cnode     <= cnode_next;
    c_node    <= c_node_next;
    made_node <= made_node_next;
    slot      <= slot_next;
  end

  assign in_item.ready              = (state == ptb_pkg::S_IDLE);
  assign out_item.valid             = (state == ptb_pkg::S_OUT);
  assign out_item.suffix_node       = last_node;
  assign out_item.palindrome_length = last_len;
  assign out_item.suffix_link_node  = last_link;
  assign out_item.is_new            = created;
  assign out_item.node_count        = nodes_used;
  assign out_item.overflow          = over;

`ifndef SYNTH
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    in_item.valid && in_item.ready |=> !in_item.ready)
    else $error("input taken while a transaction is in progress");

  a_nodes_bounded: assert property (@(posedge clk) disable iff (rst)
    (NODE_W + 1)'(nodes_used) <= (NODE_W + 1)'(position) + (NODE_W + 1)'(2))
    else $error("more nodes than letters allow");

  a_last_exists: assert property (@(posedge clk) disable iff (rst)
    last_node < nodes_used)
    else $error("last node beyond node count");

  a_new_is_last: assert property (@(posedge clk) disable iff (rst)
    out_item.valid && out_item.is_new |-> last_node == NODE_W'(nodes_used - NODE_W'(1)))
    else $error("new node is not the most recent node");
`endif

endmodule

// ===== dv/ptb_suffix_checker.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// ptb_suffix_checker
// Watches the letter and result channels of the eertree builder, keeps its
// own palindromic tree for every accepted letter and compares each result
// transaction, field by field, with the oldest predicted suffix report.
// ----------------------------------------------------------------------------
module ptb_suffix_checker
  import ptb_pkg::*;
(
  input  logic clk,
  input  logic rst,
  ptb_in_if    letters,
  ptb_out_if   reports,
  output int   fail_count,
  output int   pending,
  output int   checked,
  output int   longest
);

  localparam int PRINT_CAP = 100;

  typedef struct packed {
    logic [NODE_W-1:0] node;
    logic [POS_W-1:0]  length;
    logic [NODE_W-1:0] link;
    logic              is_new;
    logic [NODE_W-1:0] count;
    logic              overflow;
  } suffix_report_t;

  logic [LETTER_W-1:0] text_mem [0:MAX_LEN];
  int                  pal_len  [0:NODE_CAP-1];
  int unsigned         pal_link [0:NODE_CAP-1];
  int unsigned         child_of [int unsigned];
  int unsigned         last_pal;
  int unsigned         nodes_in_use;
  int unsigned         text_pos;
  suffix_report_t      reports_due [$];

  function automatic void clear_tree();
    child_of.delete();
    pal_len[IMAG_ROOT]   = -1;
    pal_link[IMAG_ROOT]  = IMAG_ROOT;
    pal_len[EMPTY_ROOT]  = 0;
    pal_link[EMPTY_ROOT] = IMAG_ROOT;
    last_pal     = EMPTY_ROOT;
    nodes_in_use = FIRST_NODE;
    text_pos     = 0;
  endfunction

  function automatic int unsigned child_at(int unsigned key);
    return child_of.exists(key) ? child_of[key] : 0;
  endfunction

  function automatic int unsigned clip_node(int unsigned n);
    return (n < NODE_CAP) ? n : IMAG_ROOT;
  endfunction

  // true if palindrome n, wrapped by ch, ends at text position p
  function automatic bit extends_at(int unsigned n, int unsigned p,
                                    logic [LETTER_W-1:0] ch);
    int idx;
    if (n == IMAG_ROOT) return 1'b1;
    idx = int'(p) - pal_len[n] - 1;
    if (idx <= 0 || idx > MAX_LEN) return 1'b0;
    return text_mem[idx] == ch;
  endfunction

  function automatic int unsigned walk_links(int unsigned n, int unsigned p,
                                             logic [LETTER_W-1:0] ch);
    n = clip_node(n);
    while (!extends_at(n, p, ch)) n = clip_node(pal_link[n]);
    return n;
  endfunction

  function automatic suffix_report_t append_letter(logic [LETTER_W-1:0] ch,
                                                   logic first);
    suffix_report_t r;
    int unsigned    x;
    int unsigned    y;
    int unsigned    key;
    int unsigned    nn;
    int unsigned    lk;
    int unsigned    n;
    bit             created;
    bit             over;
    created = 1'b0;
    over    = 1'b0;
    if (first) clear_tree();
    if (ch < ALPHABET) begin
      if (text_pos >= MAX_LEN) begin
        over = 1'b1;
      end else begin
        text_pos++;
        text_mem[text_pos] = ch;
        x   = walk_links(last_pal, text_pos, ch);
        key = x * ALPHABET + ch;
        if (child_at(key) == 0 && nodes_in_use < NODE_CAP) begin
          nn = nodes_in_use;
          nodes_in_use++;
          created       = 1'b1;
          child_of[key] = nn;
          pal_len[nn]   = pal_len[x] + 2;
          lk = EMPTY_ROOT;
          if (x != IMAG_ROOT) begin
            y  = walk_links(pal_link[x], text_pos, ch);
            lk = child_at(y * ALPHABET + ch);
            if (lk == 0) lk = EMPTY_ROOT;
          end
          pal_link[nn] = lk;
          last_pal     = nn;
        end else begin
          last_pal = clip_node(child_at(key));
        end
      end
    end
    n = clip_node(last_pal);
    r.node     = NODE_W'(n);
    r.length   = POS_W'((pal_len[n] < 0) ? 0 : pal_len[n]);
    r.link     = NODE_W'(pal_link[n]);
    r.is_new   = created;
    r.count    = NODE_W'(nodes_in_use);
    r.overflow = over;
    return r;
  endfunction

  task automatic report_mismatch(string what, int got, int want);
    if (fail_count < PRINT_CAP)
      $display("%0t ns: mismatch on %s: got %0d, expected %0d", $time, what, got, want);
    fail_count++;
  endtask

  always @(posedge clk) begin : watch
    suffix_report_t due;
    if (rst) begin
      clear_tree();
      reports_due.delete();
      fail_count = 0;
      checked    = 0;
      longest    = 0;
    end else begin
      if (letters.valid && letters.ready)
        reports_due.push_back(append_letter(letters.letter, letters.first));
      if (reports.valid && reports.ready) begin
        if (reports_due.size() == 0) begin
          report_mismatch("unexpected transaction", reports.suffix_node, 0);
        end else begin
          due = reports_due.pop_front();
          checked++;
          if (due.length > longest) longest = due.length;
          if (reports.suffix_node !== due.node)
            report_mismatch("suffix_node", reports.suffix_node, due.node);
          if (reports.palindrome_length !== due.length)
            report_mismatch("palindrome_length", reports.palindrome_length, due.length);
          if (reports.suffix_link_node !== due.link)
            report_mismatch("suffix_link_node", reports.suffix_link_node, due.link);
          if (reports.is_new !== due.is_new)
            report_mismatch("is_new", reports.is_new, due.is_new);
          if (reports.node_count !== due.count)
            report_mismatch("node_count", reports.node_count, due.count);
          if (reports.overflow !== due.overflow)
            report_mismatch("overflow", reports.overflow, due.overflow);
        end
      end
    end
    pending = reports_due.size();
  end

endmodule

// ===== dv/tb_top.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Drives letter strings into the eertree builder: directed corner letters,
// a back-pressure burst, random palindrome-rich strings, a capacity fill
// and a long suffix-link walk, with random idling on both channels; reports the verdict.
// ----------------------------------------------------------------------------
module tb_top;
  import ptb_pkg::*;

  localparam int WATCHDOG_LIMIT = 100000;
  localparam int HOLD_CYCLES    = 300;
  localparam int RANDOM_LETTERS = 450;
  localparam int DRAIN_CYCLES   = 40;
  localparam int IDLE_PCT       = 11;

  localparam logic [LETTER_W-1:0] LETTER_A   = 5'd0;
  localparam logic [LETTER_W-1:0] LETTER_B   = 5'd1;
  localparam logic [LETTER_W-1:0] LETTER_Z   = 5'd25;
  localparam logic [LETTER_W-1:0] CODE_LIMIT = 5'd31;

  logic clk = 1'b0;
  logic rst = 1'b1;

  ptb_in_if  in_if ();
  ptb_out_if out_if ();

  int fail_count;
  int pending;
  int checked;
  int longest;
  int quiet_cycles;
  int letters_sent;
  int strings_started;
  int hold_left;
  bit idle_on;
  bit hold_req;

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  palindromic_tree_builder_unit dut (
    .clk      (clk),
    .rst      (rst),
    .in_item  (in_if),
    .out_item (out_if)
  );

  ptb_suffix_checker suffix_check (
    .clk        (clk),
    .rst        (rst),
    .letters    (in_if),
    .reports    (out_if),
    .fail_count (fail_count),
    .pending    (pending),
    .checked    (checked),
    .longest    (longest)
  );

  // result sink: random stalls, plus a long hold-off on request
  initial begin
    out_if.ready = 1'b0;
    hold_left    = 0;
    forever begin
      @(negedge clk);
      if (hold_req) begin
        hold_left = HOLD_CYCLES;
        hold_req  = 1'b0;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_if.ready <= 1'b0;
      end else begin
        out_if.ready <= idle_on ? ($urandom_range(0, 99) >= IDLE_PCT) : 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (in_if.valid && in_if.ready) || (out_if.valid && out_if.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("simulation failed");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  task automatic send_letter(input logic [LETTER_W-1:0] code, input logic first_flag);
    @(negedge clk);
    while (idle_on && $urandom_range(0, 99) < IDLE_PCT) begin
      in_if.valid <= 1'b0;
      @(negedge clk);
    end
    in_if.valid  <= 1'b1;
    in_if.letter <= code;
    in_if.first  <= first_flag;
    @(posedge clk);
    while (!in_if.ready) @(posedge clk);
    letters_sent++;
    if (first_flag) strings_started++;
  endtask

  task automatic pause_until_drained();
    @(negedge clk);
    in_if.valid <= 1'b0;
    while (pending != 0) @(negedge clk);
  endtask

  initial begin
    logic [LETTER_W-1:0] word [$];
    int                  real_sent;
    int                  asz;
    int                  len;
    int                  m;
    int                  skip;
    int                  base;
    bit                  fresh;
    in_if.valid  = 1'b0;
    in_if.letter = '0;
    in_if.first  = 1'b0;
    idle_on      = 1'b1;
    hold_req     = 1'b0;
    real_sent    = 0;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // letter with no first flag lands on the string left by reset
    send_letter(LETTER_B, 1'b0);
    send_letter(LETTER_A, 1'b0);
    send_letter(LETTER_B, 1'b0);
    send_letter(CODE_LIMIT, 1'b0);
    send_letter(5'd26, 1'b1);
    send_letter(LETTER_Z, 1'b0);
    send_letter(LETTER_Z, 1'b0);
    send_letter(LETTER_A, 1'b1);
    send_letter(LETTER_A, 1'b0);
    send_letter(LETTER_Z, 1'b0);
    send_letter(LETTER_A, 1'b0);
    send_letter(LETTER_A, 1'b0);
    send_letter(5'd16, 1'b0);
    send_letter(5'd15, 1'b0);
    send_letter(5'd16, 1'b0);
    send_letter(5'd27, 1'b0);
    send_letter(5'd28, 1'b0);
    send_letter(5'd29, 1'b0);
    send_letter(5'd30, 1'b1);
    send_letter(LETTER_Z, 1'b1);
    send_letter(LETTER_Z, 1'b0);

    // sink holds off while letters keep coming
    hold_req = 1'b1;
    send_letter(LETTER_A, 1'b1);
    repeat (24) send_letter(LETTER_W'($urandom_range(0, 2)), 1'b0);
    pause_until_drained();

    while (real_sent < RANDOM_LETTERS) begin
      word.delete();
      case ($urandom_range(0, 3))
        0:       asz = 2;
        1:       asz = 3;
        2:       asz = 4;
        default: asz = ALPHABET;
      endcase
      len   = ($urandom_range(0, 9) == 0) ? $urandom_range(40, 120) : $urandom_range(1, 30);
      fresh = ($urandom_range(0, 9) != 0);
      while (word.size() < len) begin
        if (word.size() > 1 && $urandom_range(0, 3) == 0) begin
          base = word.size();
          skip = $urandom_range(0, 1);
          m    = $urandom_range(1, base - skip);
          for (int i = 0; i < m; i++) word.push_back(word[base - 1 - skip - i]);
        end else begin
          word.push_back(LETTER_W'($urandom_range(0, asz - 1)));
        end
      end
      foreach (word[i]) begin
        if ($urandom_range(0, 24) == 0)
          send_letter(LETTER_W'($urandom_range(ALPHABET, CODE_LIMIT)),
                      $urandom_range(0, 19) == 0);
        send_letter(word[i], fresh && i == 0);
        real_sent++;
        idle_on = !(real_sent >= 150 && real_sent < 260);
      end
      if ($urandom_range(0, 19) == 0) pause_until_drained();
    end
    idle_on = 1'b1;

    // fill to capacity with one letter, then overflow
    send_letter(LETTER_A, 1'b1);
    repeat (MAX_LEN - 1) send_letter(LETTER_A, 1'b0);
    send_letter(LETTER_B, 1'b0);
    send_letter(LETTER_A, 1'b0);
    send_letter(5'd30, 1'b0);
    send_letter(LETTER_Z, 1'b0);

    // long suffix-link walk on a lone break in a run
    send_letter(LETTER_A, 1'b1);
    repeat (199) send_letter(LETTER_A, 1'b0);
    send_letter(LETTER_B, 1'b0);
    repeat (200) send_letter(LETTER_A, 1'b0);

    pause_until_drained();
    repeat (DRAIN_CYCLES) @(posedge clk);
    $display("run covered %0d letters in %0d strings, incl. a %0d-letter capacity fill",
             letters_sent, strings_started, MAX_LEN);
    $display("%0d results compared, longest palindrome seen %0d", checked, longest);
    if (fail_count == 0 && pending == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
